>>> rtl/core/ecmf_pkg.sv
// Shared types and constants of the clipped-window median filter.
`default_nettype none
package ecmf_pkg;

    localparam int RADIUS_DEF    = 3;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 13;
    localparam int YW            = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 1;
    localparam int PIX_W         = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] median_value;
        logic             frame_end;
    } out_t;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_BROW   = 9'b000000100,
        S_BCOL   = 9'b000001000,
        S_GATH   = 9'b000010000,
        S_DRAIN  = 9'b000100000,
        S_SCAN   = 9'b001000000,
        S_DECIDE = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

endpackage
`default_nettype wire

>>> rtl/core/ecmf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ecmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read one entry each per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/core/edge_clipped_window_median_filter_top.sv
// Top level of the clipped-window median filter: counters, line store, gather and select.
`default_nettype none
// Pixels arrive in raster order; each transaction (pixel or flush) is followed by a check
// whether the next output's clipped window is complete. If not, the block returns to S_IDLE
// and is ready again. If so, the window of n pixels (n <= (2*RADIUS+1)^2) is read from the
// line store one pixel a cycle into a window RAM, then the median bit is resolved from MSB
// to LSB, one scan of the window RAM per bit. A result waits in an output register; the
// next transaction is taken while it waits.
module edge_clipped_window_median_filter_top #(
    parameter int RADIUS    = ecmf_pkg::RADIUS_DEF,
    parameter int MAX_WIDTH = ecmf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire ecmf_pkg::in_t                    s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output ecmf_pkg::out_t                        m_data,
    input  wire logic                             cfg_we,
    input  wire logic [ecmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ecmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SIDE = 2 * RADIUS + 1;
    localparam int WIN  = SIDE * SIDE;
    localparam int LD   = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
    localparam int AW   = $clog2(LD);
    localparam int XW   = $clog2(MAX_WIDTH + 1);
    localparam int YW   = ecmf_pkg::YW;
    localparam int NW   = $clog2(WIN + 1);
    localparam int WAW  = $clog2(WIN);
    localparam int RW   = $clog2(RADIUS + 1);
    localparam int SW   = $clog2(SIDE + 1);
    localparam int PW   = ecmf_pkg::PIX_W;

    ecmf_pkg::state_t state_reg, state_next;
    logic [ecmf_pkg::FW_BITS-1:0] fw_reg, fw_next;
    logic [ecmf_pkg::FH_BITS-1:0] fh_reg, fh_next;
    logic [XW-1:0] ix_reg, ix_next, ox_reg, ox_next;
    logic [YW-1:0] iy_reg, iy_next, oy_reg, oy_next;
    logic [AW-1:0] in_ptr_reg, in_ptr_next, out_ptr_reg, out_ptr_next;
    logic [AW-1:0] base_reg, base_next, col_ptr_reg, col_ptr_next;
    logic [RW-1:0] dyc_reg, dyc_next, dxc_reg, dxc_next;
    logic [SW-1:0] rows_reg, rows_next, cols_reg, cols_next;
    logic [SW-1:0] r_reg, r_next, c_reg, c_next;
    logic          gpend_reg, gpend_next, spend_reg, spend_next;
    logic [NW-1:0] n_reg, n_next, k_reg, k_next, cnt_reg, cnt_next;
    logic [WAW-1:0] j_reg, j_next;
    logic [2:0]    bit_reg, bit_next;
    logic [PW-1:0] mask_reg, mask_next, prefix_reg, prefix_next;
    logic          out_valid_reg, out_valid_next;
    ecmf_pkg::out_t out_data_reg, out_data_next;

    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;
    logic          accept, lwe, in_done, ready_out, match, last_out;
    logic [PW-1:0] line_rdata, win_rdata;
    logic [RW-1:0] up_c, dn_c, lf_c, rt_c;
    logic [YW-1:0] ly, down;
    logic [XW-1:0] lx, right;
    logic [NW-1:0] total;
    logic [AW:0]   sub_w, sub_x, add_w;

    // Clamp the frame registers to their usable ranges
    always_comb begin
        logic [12:0] fw13;
        fw13 = {{(13 - ecmf_pkg::FW_BITS){1'b0}}, fw_reg};
        if (fw_reg == '0) begin
            w_eff = XW'(1);
        end else if (fw13 > 13'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(fw13);
        end
        if (fh_reg == '0) begin
            h_eff = YW'(1);
        end else if (fh_reg > YW'(ecmf_pkg::MAX_HEIGHT)) begin
            h_eff = YW'(ecmf_pkg::MAX_HEIGHT);
        end else begin
            h_eff = fh_reg;
        end
    end

    // Window extent of the next output, clipped at the frame edges
    always_comb begin
        down  = h_eff - YW'(1) - oy_reg;
        right = w_eff - XW'(1) - ox_reg;
        up_c  = (oy_reg < YW'(RADIUS)) ? RW'(oy_reg) : RW'(RADIUS);
        lf_c  = (ox_reg < XW'(RADIUS)) ? RW'(ox_reg) : RW'(RADIUS);
        dn_c  = (down < YW'(RADIUS)) ? RW'(down) : RW'(RADIUS);
        rt_c  = (right < XW'(RADIUS)) ? RW'(right) : RW'(RADIUS);
        ly    = oy_reg + YW'(dn_c);
        lx    = ox_reg + XW'(rt_c);
        ready_out = (iy_reg > ly) || ((iy_reg == ly) && (ix_reg > lx));
    end

    // Ring arithmetic modulo the line store depth
    always_comb begin
        logic [AW:0] b, wx, dx;
        b  = {1'b0, base_reg};
        wx = (AW + 1)'(w_eff);
        dx = (AW + 1)'(dxc_reg);
        sub_w = (b >= wx) ? (b - wx) : (b + (AW + 1)'(LD) - wx);
        sub_x = (b >= dx) ? (b - dx) : (b + (AW + 1)'(LD) - dx);
        add_w = b + wx;
        if (add_w >= (AW + 1)'(LD)) begin
            add_w = add_w - (AW + 1)'(LD);
        end
    end

    assign in_done = (iy_reg == h_eff);
    assign s_ready = (state_reg == ecmf_pkg::S_IDLE);
    assign accept  = s_valid && s_ready;
    assign lwe     = accept && (s_data.command == ecmf_pkg::CMD_PIXEL) && !in_done;
    assign match   = (((win_rdata ^ prefix_reg) & mask_reg) == '0) && !win_rdata[bit_reg];
    assign total   = cnt_reg + NW'(match);
    assign last_out = (ox_reg == w_eff - XW'(1)) && (oy_reg == h_eff - YW'(1));

    ecmf_ram #(.WIDTH(PW), .DEPTH(LD), .AW(AW)) u_line (
        .aclk  (aclk),
        .we    (lwe),
        .waddr (in_ptr_reg),
        .wdata (s_data.pixel),
        .raddr (col_ptr_reg),
        .rdata (line_rdata)
    );

    ecmf_ram #(.WIDTH(PW), .DEPTH(WIN), .AW(WAW)) u_win (
        .aclk  (aclk),
        .we    (gpend_reg),
        .waddr (WAW'(n_reg)),
        .wdata (line_rdata),
        .raddr (j_reg),
        .rdata (win_rdata)
    );

    // Sequencer: input bookkeeping, gather, bitwise selection, result
    always_comb begin
        state_next    = state_reg;
        fw_next       = fw_reg;
        fh_next       = fh_reg;
        ix_next       = ix_reg;
        iy_next       = iy_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        in_ptr_next   = in_ptr_reg;
        out_ptr_next  = out_ptr_reg;
        base_next     = base_reg;
        col_ptr_next  = col_ptr_reg;
        dyc_next      = dyc_reg;
        dxc_next      = dxc_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        gpend_next    = 1'b0;
        spend_next    = 1'b0;
        n_next        = gpend_reg ? (n_reg + NW'(1)) : n_reg;
        k_next        = k_reg;
        cnt_next      = spend_reg ? total : cnt_reg;
        j_next        = j_reg;
        bit_next      = bit_reg;
        mask_next     = mask_reg;
        prefix_next   = prefix_reg;
        out_valid_next = (out_valid_reg && m_ready) ? 1'b0 : out_valid_reg;
        out_data_next = out_data_reg;

        unique case (state_reg)
            ecmf_pkg::S_IDLE: begin
                if (cfg_we) begin
                    if (cfg_index == ecmf_pkg::CFG_FRAME_WIDTH) begin
                        fw_next = cfg_data[ecmf_pkg::FW_BITS-1:0];
                    end else begin
                        fh_next = cfg_data[ecmf_pkg::FH_BITS-1:0];
                    end
                    ix_next = '0; iy_next = '0; ox_next = '0; oy_next = '0;
                    in_ptr_next = '0; out_ptr_next = '0;
                end else if (accept) begin
                    if (lwe) begin
                        if (ix_reg == w_eff - XW'(1)) begin
                            ix_next = '0;
                            iy_next = iy_reg + YW'(1);
                        end else begin
                            ix_next = ix_reg + XW'(1);
                        end
                        in_ptr_next = (in_ptr_reg == AW'(LD - 1)) ? '0
                                                                   : in_ptr_reg + AW'(1);
                    end
                    state_next = ecmf_pkg::S_CHECK;
                end
            end
            ecmf_pkg::S_CHECK: begin
                if (ready_out) begin
                    base_next   = out_ptr_reg;
                    dyc_next    = up_c;
                    dxc_next    = lf_c;
                    rows_next   = SW'(up_c) + SW'(dn_c) + SW'(1);
                    cols_next   = SW'(lf_c) + SW'(rt_c) + SW'(1);
                    n_next      = '0;
                    state_next  = ecmf_pkg::S_BROW;
                end else begin
                    state_next  = ecmf_pkg::S_IDLE;
                end
            end
            ecmf_pkg::S_BROW: begin
                // Step the base back one row at a time
                if (dyc_reg == '0) begin
                    state_next = ecmf_pkg::S_BCOL;
                end else begin
                    base_next = AW'(sub_w);
                    dyc_next  = dyc_reg - RW'(1);
                end
            end
            ecmf_pkg::S_BCOL: begin
                base_next    = AW'(sub_x);
                col_ptr_next = AW'(sub_x);
                r_next       = '0;
                c_next       = '0;
                state_next   = ecmf_pkg::S_GATH;
            end
            ecmf_pkg::S_GATH: begin
                // Issue one line store read per cycle, row by row
                gpend_next = 1'b1;
                if (c_reg == cols_reg - SW'(1)) begin
                    if (r_reg == rows_reg - SW'(1)) begin
                        state_next = ecmf_pkg::S_DRAIN;
                    end else begin
                        base_next    = AW'(add_w);
                        col_ptr_next = AW'(add_w);
                        c_next       = '0;
                        r_next       = r_reg + SW'(1);
                    end
                end else begin
                    col_ptr_next = (col_ptr_reg == AW'(LD - 1)) ? '0
                                                                 : col_ptr_reg + AW'(1);
                    c_next       = c_reg + SW'(1);
                end
            end
            ecmf_pkg::S_DRAIN: begin
                k_next      = (n_reg + NW'(1)) >> 1;
                j_next      = '0;
                cnt_next    = '0;
                bit_next    = 3'd7;
                mask_next   = '0;
                prefix_next = '0;
                state_next  = ecmf_pkg::S_SCAN;
            end
            ecmf_pkg::S_SCAN: begin
                // Count window entries under the prefix with a zero at the current bit
                spend_next = 1'b1;
                if (NW'(j_reg) + NW'(1) == n_reg) begin
                    j_next     = '0;
                    state_next = ecmf_pkg::S_DECIDE;
                end else begin
                    j_next = j_reg + WAW'(1);
                end
            end
            ecmf_pkg::S_DECIDE: begin
                if (k_reg >= total) begin
                    prefix_next[bit_reg] = 1'b1;
                    k_next = k_reg - total;
                end
                mask_next[bit_reg] = 1'b1;
                cnt_next = '0;
                if (bit_reg == 3'd0) begin
                    state_next = ecmf_pkg::S_OUT;
                end else begin
                    bit_next   = bit_reg - 3'd1;
                    state_next = ecmf_pkg::S_SCAN;
                end
            end
            ecmf_pkg::S_OUT: begin
                // Hold until the output register is free, then advance the output position
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next.median_value = prefix_reg;
                    out_data_next.frame_end    = last_out;
                    if (last_out) begin
                        ix_next = '0; iy_next = '0; ox_next = '0; oy_next = '0;
                        in_ptr_next = '0; out_ptr_next = '0;
                    end else begin
                        if (ox_reg == w_eff - XW'(1)) begin
                            ox_next = '0;
                            oy_next = oy_reg + YW'(1);
                        end else begin
                            ox_next = ox_reg + XW'(1);
                        end
                        out_ptr_next = (out_ptr_reg == AW'(LD - 1)) ? '0
                                                                     : out_ptr_reg + AW'(1);
                    end
                    state_next = ecmf_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ecmf_pkg::S_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ecmf_pkg::S_IDLE;
            fw_reg        <= ecmf_pkg::FW_BITS'(1024);
            fh_reg        <= ecmf_pkg::FH_BITS'(1024);
            ix_reg        <= '0;
            iy_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            in_ptr_reg    <= '0;
            out_ptr_reg   <= '0;
            gpend_reg     <= 1'b0;
            spend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            ix_reg        <= ix_next;
            iy_reg        <= iy_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            in_ptr_reg    <= in_ptr_next;
            out_ptr_reg   <= out_ptr_next;
            gpend_reg     <= gpend_next;
            spend_reg     <= spend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers without reset
    always_ff @(posedge aclk) begin
        base_reg     <= base_next;
        col_ptr_reg  <= col_ptr_next;
        dyc_reg      <= dyc_next;
        dxc_reg      <= dxc_next;
        rows_reg     <= rows_next;
        cols_reg     <= cols_next;
        r_reg        <= r_next;
        c_reg        <= c_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        cnt_reg      <= cnt_next;
        j_reg        <= j_next;
        bit_reg      <= bit_next;
        mask_reg     <= mask_next;
        prefix_reg   <= prefix_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
`default_nettype wire
